// File: src/apc_pkg.sv
// Shared constants, types and helper functions of the aliquot preimage counter.
package apc_pkg;

	localparam int TABLE_ENTRIES    = 1048576;
	localparam int COUNTER_MAX_BITS = 8;
	localparam int HIST_BINS        = 256;

	localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int HW      = $clog2(HIST_BINS);
	localparam int CLR_LEN = (TABLE_ENTRIES > HIST_BINS) ? TABLE_ENTRIES : HIST_BINS;
	localparam int CLR_W   = $clog2(CLR_LEN);

	localparam int BOUND_W    = 22;
	localparam int CB_W       = 4;
	localparam int NUM_W      = 32;
	localparam int SIG_W      = 34;
	localparam int T_W        = 36;
	localparam int BIN_W      = 8;
	localparam int IMG_W      = 5;
	localparam int HIST_W     = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;

	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W        = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] REQ_NUMBER = 2'd0;
	localparam logic [1:0] REQ_SQUARE = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOUND      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BITS = CFG_IDX_W'(1);

	localparam logic [BOUND_W-1:0] BOUND_RESET      = BOUND_W'(2097152);
	localparam logic [CB_W-1:0]    COUNT_BITS_RESET = CB_W'(8);

	typedef struct packed {
		logic [BOUND_W-1:0] bound;
		logic [CB_W-1:0]    count_bits;
	} cfg_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             chain_en;
		logic [T_W-1:0]   t0;
		logic [SIG_W-1:0] sig;
		logic             extra_en;
		logic [SIG_W-1:0] extra_x;
		logic [BIN_W-1:0] bin;
	} work_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHAIN,
		ST_EXTRA,
		ST_CRD,
		ST_CCHK,
		ST_HDEC,
		ST_HINC,
		ST_QRD,
		ST_QRES,
		ST_DONE
	} back_state_t;

	// Saturation value of a counter for the programmed width.
	function automatic logic [COUNTER_MAX_BITS:0] counter_limit(input logic [CB_W-1:0] cb);
		int eff;
		eff = int'(cb);
		if (eff < 1) eff = 1;
		if (eff > COUNTER_MAX_BITS) eff = COUNTER_MAX_BITS;
		return (COUNTER_MAX_BITS+1)'((1 << eff) - 1);
	endfunction

	// Even image, at least two, within bound and within the table.
	function automatic logic recordable(input logic [T_W-1:0] x, input logic [BOUND_W-1:0] bnd);
		return (x[0] == 1'b0) && (x >= T_W'(2)) && (x <= T_W'(bnd))
			&& (x[T_W-1:1] <= (T_W-1)'(TABLE_ENTRIES));
	endfunction

	function automatic logic [AW-1:0] rec_index(input logic [T_W-1:0] x);
		logic [T_W-2:0] h;
		h = x[T_W-1:1] - (T_W-1)'(1);
		return h[AW-1:0];
	endfunction

endpackage

// File: src/apc_front.sv
// Front end: takes request beats, classifies them and works out chain start and extra image.
module apc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apc_pkg::back_status_t          status,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [apc_pkg::NUM_W-1:0]      number,
	input  logic [apc_pkg::SIG_W-1:0]      divisor_sum,
	input  logic [apc_pkg::BIN_W-1:0]      bin,
	output logic                           push,
	output apc_pkg::work_item_t            push_data,
	input  logic                           q_full
);

	logic                          v_s1;
	logic [1:0]                    kind_s1;
	logic [apc_pkg::NUM_W-1:0]     n_s1;
	logic [apc_pkg::SIG_W-1:0]     sig_s1;
	logic [apc_pkg::BIN_W-1:0]     bin_s1;
	logic [apc_pkg::T_W-1:0]       three_sig_s1;
	logic [apc_pkg::NUM_W:0]       n_plus1_s1;

	logic                          load;
	logic [apc_pkg::T_W-1:0]       two_n;
	logic                          is_prime;

	assign in_ready = !status.clearing && (!v_s1 || !q_full);
	assign load     = in_valid && in_ready;
	assign push     = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1      <= req_type;
			n_s1         <= number;
			sig_s1       <= divisor_sum;
			bin_s1       <= bin;
			three_sig_s1 <= apc_pkg::T_W'(divisor_sum) + apc_pkg::T_W'({divisor_sum, 1'b0});
			n_plus1_s1   <= {1'b0, number} + (apc_pkg::NUM_W+1)'(1);
		end
	end

	assign two_n    = apc_pkg::T_W'({n_s1, 1'b0});
	assign is_prime = (sig_s1 == apc_pkg::SIG_W'(n_plus1_s1));

	always_comb begin
		push_data.kind     = kind_s1;
		push_data.chain_en = (kind_s1 == apc_pkg::REQ_NUMBER) && !sig_s1[0]
			&& (three_sig_s1 >= two_n);
		push_data.t0       = three_sig_s1 - two_n;
		push_data.sig      = sig_s1;
		push_data.bin      = bin_s1;
		push_data.extra_en = 1'b0;
		push_data.extra_x  = apc_pkg::SIG_W'(n_plus1_s1);
		case (kind_s1)
			apc_pkg::REQ_NUMBER: begin
				push_data.extra_en = is_prime;
			end
			apc_pkg::REQ_SQUARE: begin
				// square excess sigma - n
				push_data.extra_en = !is_prime && (n_s1 > apc_pkg::NUM_W'(1))
					&& (sig_s1 >= apc_pkg::SIG_W'(n_s1));
				push_data.extra_x  = sig_s1 - apc_pkg::SIG_W'(n_s1);
			end
			default: begin
				push_data.extra_en = 1'b0;
			end
		endcase
	end

endmodule

// File: src/apc_queue.sv
// Short queue of classified work items between front end and back end.
module apc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  apc_pkg::work_item_t  push_data,
	output logic                 full,
	input  logic                 pop,
	output apc_pkg::work_item_t  pop_data,
	output logic                 empty
);

	apc_pkg::work_item_t          slots_q [apc_pkg::QUEUE_DEPTH];
	logic [apc_pkg::QA_W-1:0]     wr_ptr_q;
	logic [apc_pkg::QA_W-1:0]     rd_ptr_q;
	logic [apc_pkg::QA_W:0]       count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full     = (count_q == (apc_pkg::QA_W+1)'(apc_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + apc_pkg::QA_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + apc_pkg::QA_W'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + (apc_pkg::QA_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (apc_pkg::QA_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: src/apc_back.sv
// Back end: walks each chain and does counter and histogram read-modify-writes.
module apc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apc_pkg::cfg_t                 cfg,
	input  logic                          q_empty,
	input  apc_pkg::work_item_t           q_data,
	output logic                          q_pop,
	output apc_pkg::back_status_t         status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [apc_pkg::IMG_W-1:0]     images_counted,
	output logic [apc_pkg::HIST_W-1:0]    bin_total
);

	localparam int CMB = apc_pkg::COUNTER_MAX_BITS;

	apc_pkg::back_state_t          state_q, state_d;
	logic [apc_pkg::CLR_W-1:0]     clr_q, clr_d;
	apc_pkg::work_item_t           ent_q, ent_d;
	logic [apc_pkg::T_W-1:0]       t_q, t_d;
	logic [apc_pkg::AW-1:0]        idx_q, idx_d;
	logic                          in_chain_q, in_chain_d;
	logic [apc_pkg::IMG_W-1:0]     images_q, images_d;
	logic [CMB-1:0]                v_q, v_d;
	logic [apc_pkg::HIST_W-1:0]    total_q, total_d;

	logic                          out_valid_q;
	logic [apc_pkg::IMG_W-1:0]     images_out_q;
	logic [apc_pkg::HIST_W-1:0]    total_out_q;
	logic                          out_load;

	logic [CMB-1:0]                cnt_mem [apc_pkg::TABLE_ENTRIES];
	logic [CMB-1:0]                cnt_rdata_q;
	logic                          cnt_we, cnt_re;
	logic [apc_pkg::AW-1:0]        cnt_waddr, cnt_raddr;
	logic [CMB-1:0]                cnt_wdata;

	logic [apc_pkg::HIST_W-1:0]    hist_mem [apc_pkg::HIST_BINS];
	logic [apc_pkg::HIST_W-1:0]    hist_rdata_q;
	logic                          hist_we, hist_re;
	logic [apc_pkg::HW-1:0]        hist_waddr, hist_raddr;
	logic [apc_pkg::HIST_W-1:0]    hist_wdata;

	logic [CMB:0]                  limit;
	logic [CMB:0]                  v_inc;
	logic                          chain_go;
	logic [apc_pkg::T_W-1:0]       t_next;
	logic [apc_pkg::T_W-1:0]       x_extra;
	apc_pkg::back_state_t          ret_state;

	assign limit     = apc_pkg::counter_limit(cfg.count_bits);
	assign v_inc     = {1'b0, v_q} + (CMB+1)'(1);
	assign chain_go  = (t_q != '0) && (t_q <= apc_pkg::T_W'(cfg.bound));
	assign t_next    = apc_pkg::T_W'({t_q[apc_pkg::BOUND_W-1:0], 1'b0})
		+ apc_pkg::T_W'(ent_q.sig);
	assign x_extra   = apc_pkg::T_W'(ent_q.extra_x);
	assign ret_state = in_chain_q ? apc_pkg::ST_CHAIN : apc_pkg::ST_DONE;

	assign status.clearing = (state_q == apc_pkg::ST_CLEAR);
	assign out_valid       = out_valid_q;
	assign images_counted  = images_out_q;
	assign bin_total       = total_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apc_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q      <= ent_d;
		t_q        <= t_d;
		idx_q      <= idx_d;
		in_chain_q <= in_chain_d;
		images_q   <= images_d;
		v_q        <= v_d;
		total_q    <= total_d;
		if (out_load) begin
			images_out_q <= images_q;
			total_out_q  <= total_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		ent_d      = ent_q;
		t_d        = t_q;
		idx_d      = idx_q;
		in_chain_d = in_chain_q;
		images_d   = images_q;
		v_d        = v_q;
		total_d    = total_q;
		q_pop      = 1'b0;
		out_load   = 1'b0;
		cnt_we     = 1'b0;
		cnt_re     = 1'b0;
		cnt_waddr  = idx_q;
		cnt_raddr  = idx_q;
		cnt_wdata  = '0;
		hist_we    = 1'b0;
		hist_re    = 1'b0;
		hist_waddr = apc_pkg::HW'(v_q);
		hist_raddr = apc_pkg::HW'(v_q);
		hist_wdata = '0;
		unique case (state_q)
			apc_pkg::ST_CLEAR: begin
				cnt_we     = (32'(clr_q) < apc_pkg::TABLE_ENTRIES);
				cnt_waddr  = clr_q[apc_pkg::AW-1:0];
				hist_we    = (32'(clr_q) < apc_pkg::HIST_BINS);
				hist_waddr = clr_q[apc_pkg::HW-1:0];
				hist_wdata = (clr_q == '0) ? apc_pkg::HIST_W'(apc_pkg::TABLE_ENTRIES) : '0;
				if (clr_q == apc_pkg::CLR_W'(apc_pkg::CLR_LEN - 1)) begin
					state_d = apc_pkg::ST_IDLE;
				end else begin
					clr_d = clr_q + apc_pkg::CLR_W'(1);
				end
			end
			apc_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					ent_d    = q_data;
					t_d      = q_data.t0;
					images_d = '0;
					total_d  = '0;
					case (q_data.kind)
						apc_pkg::REQ_NUMBER: begin
							state_d = q_data.chain_en ? apc_pkg::ST_CHAIN : apc_pkg::ST_EXTRA;
						end
						apc_pkg::REQ_SQUARE: state_d = apc_pkg::ST_EXTRA;
						apc_pkg::REQ_QUERY:  state_d = apc_pkg::ST_QRD;
						default:             state_d = apc_pkg::ST_DONE;
					endcase
				end
			end
			apc_pkg::ST_CHAIN: begin
				if (chain_go) begin
					t_d = t_next;
					if (apc_pkg::recordable(t_q, cfg.bound)) begin
						idx_d      = apc_pkg::rec_index(t_q);
						in_chain_d = 1'b1;
						state_d    = apc_pkg::ST_CRD;
					end
				end else begin
					state_d = apc_pkg::ST_EXTRA;
				end
			end
			apc_pkg::ST_EXTRA: begin
				if (ent_q.extra_en && apc_pkg::recordable(x_extra, cfg.bound)) begin
					idx_d      = apc_pkg::rec_index(x_extra);
					in_chain_d = 1'b0;
					state_d    = apc_pkg::ST_CRD;
				end else begin
					state_d = apc_pkg::ST_DONE;
				end
			end
			apc_pkg::ST_CRD: begin
				cnt_re  = 1'b1;
				state_d = apc_pkg::ST_CCHK;
			end
			apc_pkg::ST_CCHK: begin
				// a saturated counter still counts as a recorded image
				images_d = images_q + apc_pkg::IMG_W'(1);
				v_d      = cnt_rdata_q;
				state_d  = ret_state;
				if ({1'b0, cnt_rdata_q} < limit) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_rdata_q + CMB'(1);
					if (32'(cnt_rdata_q) < apc_pkg::HIST_BINS) begin
						hist_re    = 1'b1;
						hist_raddr = apc_pkg::HW'(cnt_rdata_q);
						state_d    = apc_pkg::ST_HDEC;
					end
				end
			end
			apc_pkg::ST_HDEC: begin
				hist_we    = 1'b1;
				hist_waddr = apc_pkg::HW'(v_q);
				hist_wdata = hist_rdata_q - apc_pkg::HIST_W'(1);
				if (32'(v_inc) < apc_pkg::HIST_BINS) begin
					hist_re    = 1'b1;
					hist_raddr = apc_pkg::HW'(v_inc);
					state_d    = apc_pkg::ST_HINC;
				end else begin
					state_d = ret_state;
				end
			end
			apc_pkg::ST_HINC: begin
				hist_we    = 1'b1;
				hist_waddr = apc_pkg::HW'(v_inc);
				hist_wdata = hist_rdata_q + apc_pkg::HIST_W'(1);
				state_d    = ret_state;
			end
			apc_pkg::ST_QRD: begin
				if (32'(ent_q.bin) < apc_pkg::HIST_BINS) begin
					hist_re    = 1'b1;
					hist_raddr = apc_pkg::HW'(ent_q.bin);
					state_d    = apc_pkg::ST_QRES;
				end else begin
					state_d = apc_pkg::ST_DONE;
				end
			end
			apc_pkg::ST_QRES: begin
				total_d = hist_rdata_q;
				state_d = apc_pkg::ST_DONE;
			end
			apc_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = apc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = apc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		if (cnt_re) cnt_rdata_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		if (hist_re) hist_rdata_q <= hist_mem[hist_raddr];
	end

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_CLEAR) |-> !q_pop)
		else $error("work item taken during clearing pass");

	a_count_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_we && state_q != apc_pkg::ST_CLEAR) |-> ({1'b0, cnt_wdata} <= limit))
		else $error("counter written beyond saturation value");

	a_inc_after_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apc_pkg::ST_HINC) |-> ($past(state_q) == apc_pkg::ST_HDEC))
		else $error("histogram increment without preceding decrement");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

endmodule

// File: src/aliquot_preimage_counter.sv
// Aliquot preimage counter top level: configuration registers, front end, queue and back end.
//
// After reset the block runs a clearing pass over 1048576 counter entries (one entry a cycle,
// the histogram being set up in the first 256 steps) and takes no request beat until it
// ends; configuration writes are taken throughout. A request is then registered in the
// front end and waits in a four-entry queue for the back end, which works on one item at a
// time over the counter memory: it picks the item up, tests each chain term in turn, then
// the extra image, and for each recorded image reads the counter, checks and writes it, and
// decrements and increments the histogram (only the read and the check when the counter is
// saturated), then hands the result to the output register, waiting while that is held. A
// query picks up its item, reads its histogram bin and hands the total on in the same way.
module aliquot_preimage_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [apc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [apc_pkg::NUM_W-1:0]           number,
	input  logic [apc_pkg::SIG_W-1:0]           divisor_sum,
	input  logic [apc_pkg::BIN_W-1:0]           bin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [apc_pkg::IMG_W-1:0]           images_counted,
	output logic [apc_pkg::HIST_W-1:0]          bin_total
);

	apc_pkg::cfg_t          cfg_q;
	apc_pkg::back_status_t  status;
	apc_pkg::work_item_t    push_data;
	apc_pkg::work_item_t    pop_data;
	logic                   push;
	logic                   q_full;
	logic                   q_pop;
	logic                   q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bound      <= apc_pkg::BOUND_RESET;
			cfg_q.count_bits <= apc_pkg::COUNT_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				apc_pkg::CFG_BOUND:      cfg_q.bound      <= cfg_data[apc_pkg::BOUND_W-1:0];
				apc_pkg::CFG_COUNT_BITS: cfg_q.count_bits <= cfg_data[apc_pkg::CB_W-1:0];
				default: begin
					// drop writes to unused indexes
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	apc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.status      (status),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.number      (number),
		.divisor_sum (divisor_sum),
		.bin         (bin),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	apc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	apc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_empty),
		.q_data         (pop_data),
		.q_pop          (q_pop),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.images_counted (images_counted),
		.bin_total      (bin_total)
	);

endmodule
